FILE: rtl/bb3_pkg.sv
// Package for the 3x3 box blur: payload types, register indexes, fixed-point constants.
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 12;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [COLSUM_W-1:0]   colsum_t;
    typedef logic [SUM_W-1:0]      sum_t;

    // Register indexes
    localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

    // floor(S/9) == (S * 7282) >> 16 for all S < 32768
    localparam logic [RECIP_W-1:0] RECIP_NINE_Q16 = 13'd7282;
    localparam int                 RECIP_SHIFT    = 16;

    localparam int MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_DIM      = 3;

endpackage
`default_nettype wire

FILE: rtl/bb3_if.sv
// Valid/ready channel interfaces: pixel input, blurred result output, config writes.
`timescale 1ns / 1ps
`default_nettype none
interface bb3_pix_if;
    import bb3_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bb3_res_if;
    import bb3_pkg::*;
    logic valid;
    logic ready;
    pix_t blurred;
    logic row_end;
    logic frame_end;
    modport source (output valid, output blurred, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input blurred, input row_end, input frame_end,
                    output ready);
endinterface

interface bb3_cfg_if;
    import bb3_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/box_blur_3x3.sv
// Top level of the 3x3 box blur: line buffers, window column sums, mean pipeline.
//
// Usage:
//   pix  : pixel stream in raster order, one transaction per pixel.
//   res  : one transaction per interior pixel (rows 1..H-2, columns 1..W-2),
//          blurred = floor(mean of 3x3 neighborhood); row_end marks the last
//          interior pixel of a row, frame_end the last of the frame.
//   cfg  : register writes (index 0 image_width, 1 image_height); always ready.
//          Any write to a known register restarts the frame at row 0, column 0.
//          Write only while the block is idle. Unknown indexes are ignored.
// Throughput: one pixel per clock, sustained; ready only drops when all three
//   stages are full and the receiver is stalling.
// Pipeline: a pixel completing its window goes through the line-buffer read
//   (stage 1), the column sum + add (stage 2) and the multiply by the reciprocal
//   of nine (stage 3), whose registers drive res; a stalled stage holds its item.
// Line buffers: two single-port-per-side RAMs of MAX_WIDTH bytes; contents
//   are undefined after reset, no clearing pass is needed since a result only
//   uses entries written earlier in the same frame.
// Reset: pipeline empty, width 640 (MAX_WIDTH if smaller), height 480, position at frame start.
// Stall: results hold on res until taken; up to three items stay in flight.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bb3_pix_if.sink    pix,
    bb3_res_if.source  res,
    bb3_cfg_if.sink    cfg
);
    import bb3_pkg::*;

    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RST_WLAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

    typedef logic [AW-1:0] col_t;

    // ---------------- configuration ----------------
    col_t wlast_reg, wlast_next;
    row_t hlast_reg, hlast_next;
    logic cfg_hit;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        cfg_hit    = 1'b0;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (cfg.data < cfg_data_t'(MIN_DIM))
                        wlast_next = col_t'(MIN_DIM - 1);
                    else if (32'(cfg.data) > 32'(MAX_WIDTH))
                        wlast_next = col_t'(MAX_WIDTH - 1);
                    else
                        wlast_next = col_t'(cfg.data - cfg_data_t'(1));
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (cfg.data < cfg_data_t'(MIN_DIM))
                        hlast_next = row_t'(MIN_DIM - 1);
                    else if (32'(cfg.data) > 32'(MAX_HEIGHT))
                        hlast_next = row_t'(MAX_HEIGHT - 1);
                    else
                        hlast_next = row_t'(cfg.data - cfg_data_t'(1));
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic en_out, en2, en1, acc;

    assign en_out    = !out_valid_reg || res.ready;
    assign en2       = !s2_valid_reg || en_out;
    assign en1       = !s1_valid_reg || en2;
    assign pix.ready = en1;
    assign acc       = pix.valid && en1;

    // ---------------- raster position ----------------
    col_t col_reg, col_next;
    row_t row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (acc)
        begin
            if (col_reg == wlast_reg)
            begin
                col_next = '0;
                row_next = (row_reg == hlast_reg) ? '0 : row_t'(row_reg + row_t'(1));
            end
            else
            begin
                col_next = col_t'(col_reg + col_t'(1));
            end
        end
    end

    // ---------------- line buffers ----------------
    pix_t line_above_mem     [MAX_WIDTH];
    pix_t line_two_above_mem [MAX_WIDTH];
    pix_t above_reg, two_above_reg;   // registered read data, part of stage 1
    logic wr2_valid_reg;
    col_t wr2_addr_reg;

    // Read-before-write on line_above; line_two_above takes the old
    // line_above entry in the cycle after the read, once it has been read out.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            above_reg              <= line_above_mem[col_reg];
            two_above_reg          <= line_two_above_mem[col_reg];
            line_above_mem[col_reg] <= pix.pixel;
        end
        if (wr2_valid_reg)
            line_two_above_mem[wr2_addr_reg] <= above_reg;
    end

    // ---------------- stage 1: new window column ----------------
    pix_t s1_pix_reg;
    logic s1_prod_reg, s1_row_end_reg, s1_frame_end_reg;
    logic prod_now, row_end_now;

    assign prod_now    = (row_reg >= row_t'(2)) && (col_reg >= col_t'(2));
    assign row_end_now = (col_reg == wlast_reg);

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg       <= pix.pixel;
            s1_prod_reg      <= prod_now;
            s1_row_end_reg   <= row_end_now;
            s1_frame_end_reg <= row_end_now && (row_reg == hlast_reg);
            wr2_addr_reg     <= col_reg;
        end
    end

    // ---------------- stage 2: window sum ----------------
    // Window kept as the sums of its two older columns.
    colsum_t cs0_reg, cs1_reg, cs_new;
    sum_t    s2_sum_reg, sum_new;
    logic    s2_row_end_reg, s2_frame_end_reg;
    logic    s1_move;

    assign s1_move = s1_valid_reg && en2;
    assign cs_new  = colsum_t'(two_above_reg) + colsum_t'(above_reg) + colsum_t'(s1_pix_reg);
    assign sum_new = sum_t'(cs0_reg) + sum_t'(cs1_reg) + sum_t'(cs_new);

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_sum_reg       <= sum_new;
            s2_row_end_reg   <= s1_row_end_reg;
            s2_frame_end_reg <= s1_frame_end_reg;
        end
    end

    // ---------------- stage 3: divide by nine ----------------
    logic [PROD_W-1:0] prod;
    pix_t              out_blurred_reg;
    logic              out_row_end_reg, out_frame_end_reg;

    assign prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP_NINE_Q16);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && en_out)
        begin
            out_blurred_reg   <= prod[RECIP_SHIFT +: PIX_W];
            out_row_end_reg   <= s2_row_end_reg;
            out_frame_end_reg <= s2_frame_end_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.blurred   = out_blurred_reg;
    assign res.row_end   = out_row_end_reg;
    assign res.frame_end = out_frame_end_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg     <= col_t'(RST_WLAST);
            hlast_reg     <= row_t'(RESET_HEIGHT - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            wr2_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cs0_reg       <= '0;
            cs1_reg       <= '0;
        end
        else
        begin
            wlast_reg     <= wlast_next;
            hlast_reg     <= hlast_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            wr2_valid_reg <= acc;
            if (en1)
                s1_valid_reg <= pix.valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg && s1_prod_reg;
            if (en_out)
                out_valid_reg <= s2_valid_reg;
            if (s1_move)
            begin
                cs0_reg <= cs1_reg;
                cs1_reg <= cs_new;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bb3_checker.sv
// Port-level checker for the 3x3 box blur and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bb3_port_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pix_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [7:0] res_blurred,
    input wire logic res_row_end,
    input wire logic res_frame_end
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_blurred))
        else $error("blurred changed while stalled");

    // The last pixel of a frame is also the last of its row.
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_frame_end |-> res_row_end)
        else $error("frame_end without row_end");

    // Input backpressure only comes from a stalled output.
    a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("input stalled without output stall");

    // Nothing is offered while in reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind box_blur_3x3 bb3_port_checker u_bb3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_ready     (pix.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_blurred   (res.blurred),
    .res_row_end   (res.row_end),
    .res_frame_end (res.frame_end)
);
`default_nettype wire
